[rtl/mtep_pkg.sv]
// ----------------------------------------------------------------------------
// mtep_pkg
// Shared types, codes and helpers for the MIDI track event parser.
// ----------------------------------------------------------------------------
package mtep_pkg;

	localparam int IN_DEPTH_DEF  = 2;
	localparam int OUT_DEPTH_DEF = 2;

	localparam logic [7:0] STATUS_MIN   = 8'h80;
	localparam logic [7:0] SYSEX_LAST   = 8'hEF;
	localparam logic [7:0] META_STATUS  = 8'hFF;
	localparam logic [7:0] META_TEMPO   = 8'h51;
	localparam logic [7:0] META_EOT     = 8'h2F;

	localparam logic [3:0] KIND_PROGRAM  = 4'd4;
	localparam logic [3:0] KIND_PRESSURE = 4'd5;
	localparam logic [3:0] KIND_SYSEX    = 4'd7;
	localparam logic [3:0] KIND_META     = 4'd8;
	localparam logic [3:0] KIND_UNKNOWN  = 4'd9;

	localparam logic [1:0] ERR_OK       = 2'd0;
	localparam logic [1:0] ERR_SHORT    = 2'd1;
	localparam logic [1:0] ERR_UNKNOWN  = 2'd2;
	localparam logic [1:0] ERR_OVERFLOW = 2'd3;

	// one classified track byte
	typedef struct packed {
		logic [7:0] data_byte;
		logic       track_start;
		logic       is_status;
		logic [3:0] kind;
	} front_item_t;

	typedef struct packed {
		logic [27:0] delta_pulses;
		logic [7:0]  status_byte;
		logic [3:0]  event_kind;
		logic [7:0]  first_data;
		logic [7:0]  second_data;
		logic [7:0]  meta_kind;
		logic [23:0] tempo_us_per_quarter;
		logic        end_of_track;
		logic [1:0]  error_code;
	} result_t;

	function automatic logic [3:0] kind_of(input logic [7:0] s);
		logic [3:0] k;
		if (s > SYSEX_LAST && s < META_STATUS) k = KIND_SYSEX;
		else if (s < STATUS_MIN) k = KIND_UNKNOWN;
		else if (s == META_STATUS) k = KIND_META;
		else k = {1'b0, s[6:4]};
		return k;
	endfunction

endpackage

[rtl/mtep_fifo.sv]
// ----------------------------------------------------------------------------
// mtep_fifo
// Small first-word-fall-through queue built from registers.
// ----------------------------------------------------------------------------
module mtep_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd) rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd) count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr) count_q <= count_q - 1'b1;
		end
	end

endmodule

[rtl/mtep_front.sv]
// ----------------------------------------------------------------------------
// mtep_front
// Accepts track bytes, tags status bytes with their event kind and queues them.
// ----------------------------------------------------------------------------
module mtep_front import mtep_pkg::*; #(
	parameter int DEPTH = IN_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic [7:0]  data_byte,
	input  logic        track_start,
	output logic        full,
	input  logic        take,
	output front_item_t item,
	output logic        item_valid
);

	front_item_t cls;
	logic [$bits(front_item_t)-1:0] rd_bits;
	logic empty;

	always_comb begin
		cls.data_byte   = data_byte;
		cls.track_start = track_start;
		cls.is_status   = data_byte[7];
		cls.kind        = kind_of(data_byte);
	end

	mtep_fifo #(.WIDTH($bits(front_item_t)), .DEPTH(DEPTH)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (cls),
		.full    (full),
		.rd_en   (take),
		.rd_data (rd_bits),
		.empty   (empty)
	);

	assign item       = front_item_t'(rd_bits);
	assign item_valid = !empty;

endmodule

[rtl/mtep_back.sv]
// ----------------------------------------------------------------------------
// mtep_back
// Event parser: walks delta, status and body bytes and builds one result
// per finished event.
// ----------------------------------------------------------------------------
module mtep_back import mtep_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        delta_present,
	input  front_item_t item,
	input  logic        item_valid,
	output logic        take,
	input  logic        res_full,
	output logic        res_valid,
	output result_t     res
);

	typedef enum logic [3:0] {
		PH_START, PH_STATUS, PH_DATA1, PH_DATA2, PH_META_TYPE,
		PH_META_LEN, PH_META_PAY, PH_SYX_LEN, PH_SYX_PAY
	} phase_t;

	phase_t      phase_q, n_phase;
	logic [7:0]  rs_q, n_rs, hs_q, n_hs, hf_q, n_hf, hm_q, n_hm, b;
	logic [27:0] acc_q, n_acc, rem_q, n_rem, hd_q, n_hd;
	logic [2:0]  cnt_q, n_cnt;
	logic [23:0] tempo_q, n_tempo;
	logic [1:0]  pidx_q, n_pidx;
	logic [3:0]  k;
	logic        run_status, run_body, emit, vlq_done, vlq_ovf;

	assign take = item_valid && !res_full;

	always_comb begin
		n_phase = phase_q; n_rs = rs_q; n_acc = acc_q; n_cnt = cnt_q;
		n_rem = rem_q; n_hd = hd_q; n_hs = hs_q; n_hf = hf_q; n_hm = hm_q;
		n_tempo = tempo_q; n_pidx = pidx_q;
		b = item.data_byte;
		k = '0;
		run_status = 1'b0; run_body = 1'b0; emit = 1'b0;
		vlq_done = 1'b0; vlq_ovf = 1'b0;
		res = '0;
		if (take) begin
			if (item.track_start) n_rs = '0;
			// a new event starts from a clean slate
			if (item.track_start || phase_q == PH_START) begin
				n_phase = PH_START; n_acc = '0; n_cnt = '0; n_rem = '0; n_hd = '0;
				n_hs = '0; n_hf = '0; n_hm = '0; n_tempo = '0; n_pidx = '0;
			end
			if (n_phase == PH_START) begin
				if (!delta_present) run_status = 1'b1;
				else begin
					n_acc = {n_acc[20:0], b[6:0]};
					n_cnt = n_cnt + 3'd1;
					n_hd  = n_acc;
					if (b[7] && n_cnt >= 3'd4) begin
						emit = 1'b1;
						res.event_kind = KIND_UNKNOWN;
						res.error_code = ERR_OVERFLOW;
					end else if (!b[7]) n_phase = PH_STATUS;
				end
			end else if (n_phase == PH_STATUS) run_status = 1'b1;
			else run_body = 1'b1;

			if (run_status) begin
				if (item.is_status) begin
					n_hs = b;
					n_rs = b;
					k = item.kind;
				end else begin
					n_hs = n_rs;
					k = kind_of(n_hs);
					run_body = 1'b1;
				end
				if (k == KIND_UNKNOWN) begin
					// data byte with no running status: drop it and emit an unknown-event error result
					run_body = 1'b0;
					emit = 1'b1;
					res.status_byte = n_hs;
					res.event_kind  = KIND_UNKNOWN;
					res.error_code  = ERR_UNKNOWN;
				end else if (k == KIND_META) n_phase = PH_META_TYPE;
				else if (k == KIND_SYSEX) begin
					n_acc = '0; n_cnt = '0; n_phase = PH_SYX_LEN;
				end else n_phase = PH_DATA1;
			end

			if (run_body) begin
				k = kind_of(n_hs);
				res.status_byte = n_hs;
				unique case (n_phase)
					PH_DATA1: begin
						if (k == KIND_PROGRAM || k == KIND_PRESSURE) begin
							emit = 1'b1;
							res.event_kind = k;
							res.first_data = b;
						end else begin
							n_hf = b;
							n_phase = PH_DATA2;
						end
					end
					PH_DATA2: begin
						emit = 1'b1;
						res.event_kind  = k;
						res.first_data  = n_hf;
						res.second_data = b;
					end
					PH_META_TYPE: begin
						n_hm = b; n_acc = '0; n_cnt = '0; n_phase = PH_META_LEN;
					end
					PH_META_LEN, PH_SYX_LEN: begin
						n_acc = {n_acc[20:0], b[6:0]};
						n_cnt = n_cnt + 3'd1;
						vlq_done = !b[7];
						vlq_ovf  = b[7] && n_cnt >= 3'd4;
						res.event_kind = (n_phase == PH_META_LEN) ? KIND_META : KIND_SYSEX;
						if (n_phase == PH_META_LEN) res.meta_kind = n_hm;
						if (vlq_ovf) begin
							emit = 1'b1;
							res.error_code = ERR_OVERFLOW;
						end else if (vlq_done) begin
							n_rem = n_acc;
							if (n_phase == PH_META_LEN) begin
								n_tempo = '0; n_pidx = '0;
							end
							if (n_acc == '0) emit = 1'b1;
							else n_phase = (n_phase == PH_META_LEN) ? PH_META_PAY : PH_SYX_PAY;
						end
					end
					PH_META_PAY: begin
						if (n_pidx != 2'd3) begin
							n_tempo = {n_tempo[15:0], b};
							n_pidx  = n_pidx + 2'd1;
						end
						n_rem = n_rem - 28'd1;
						res.event_kind = KIND_META;
						res.meta_kind  = n_hm;
						if (n_rem == '0) emit = 1'b1;
					end
					PH_SYX_PAY: begin
						n_rem = n_rem - 28'd1;
						res.event_kind = KIND_SYSEX;
						if (n_rem == '0) emit = 1'b1;
					end
					default: begin
						emit = 1'b0;
					end
				endcase
				// close out a meta event that ended without overflow
				if (emit && res.event_kind == KIND_META && res.error_code == ERR_OK) begin
					if (n_hm == META_TEMPO) begin
						if (n_pidx == 2'd3) res.tempo_us_per_quarter = n_tempo;
						else res.error_code = ERR_SHORT;
					end
				end
			end

			if (emit) begin
				res.delta_pulses = n_hd;
				res.end_of_track = (res.event_kind == KIND_META) && (res.meta_kind == META_EOT);
				n_phase = PH_START; n_acc = '0; n_cnt = '0; n_rem = '0; n_hd = '0;
				n_hs = '0; n_hf = '0; n_hm = '0; n_tempo = '0; n_pidx = '0;
			end
		end
	end

	assign res_valid = take && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			rs_q    <= '0;
			acc_q   <= '0;
			cnt_q   <= '0;
			rem_q   <= '0;
			hd_q    <= '0;
			hs_q    <= '0;
			hf_q    <= '0;
			hm_q    <= '0;
			tempo_q <= '0;
			pidx_q  <= '0;
		end else begin
			phase_q <= n_phase;
			rs_q    <= n_rs;
			acc_q   <= n_acc;
			cnt_q   <= n_cnt;
			rem_q   <= n_rem;
			hd_q    <= n_hd;
			hs_q    <= n_hs;
			hf_q    <= n_hf;
			hm_q    <= n_hm;
			tempo_q <= n_tempo;
			pidx_q  <= n_pidx;
		end
	end

endmodule

[rtl/midi_track_event_parser.sv]
// ----------------------------------------------------------------------------
// midi_track_event_parser
// Standard MIDI File track event parser, one track byte per cycle while the result queue has room.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; the parser takes one byte from the input
// queue each cycle that the result queue has room.
// A result is written into the result queue on the edge that accepts the last
// byte of its event, and reaches the result ports once older results are popped.
// Reset: arst_n clears both queues, the parser state and running status, and
// sets delta_present to 1.
module midi_track_event_parser import mtep_pkg::*; #(
	parameter int IN_DEPTH  = IN_DEPTH_DEF,
	parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic        delta_present,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        track_start,
	output logic        empty,
	input  logic        pop,
	output logic [27:0] delta_pulses,
	output logic [7:0]  status_byte,
	output logic [3:0]  event_kind,
	output logic [7:0]  first_data,
	output logic [7:0]  second_data,
	output logic [7:0]  meta_kind,
	output logic [23:0] tempo_us_per_quarter,
	output logic        end_of_track,
	output logic [1:0]  error_code
);

	logic        delta_present_q;
	front_item_t item;
	logic        item_valid, take, res_full, res_valid;
	result_t     res, head;
	logic [$bits(result_t)-1:0] head_bits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) delta_present_q <= 1'b1;
		else if (cfg_write) delta_present_q <= delta_present;
	end

	mtep_front #(.DEPTH(IN_DEPTH)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.data_byte   (data_byte),
		.track_start (track_start),
		.full        (full),
		.take        (take),
		.item        (item),
		.item_valid  (item_valid)
	);

	mtep_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.delta_present (delta_present_q),
		.item          (item),
		.item_valid    (item_valid),
		.take          (take),
		.res_full      (res_full),
		.res_valid     (res_valid),
		.res           (res)
	);

	mtep_fifo #(.WIDTH($bits(result_t)), .DEPTH(OUT_DEPTH)) u_res_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_valid),
		.wr_data (res),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (head_bits),
		.empty   (empty)
	);

	assign head                 = result_t'(head_bits);
	assign delta_pulses         = head.delta_pulses;
	assign status_byte          = head.status_byte;
	assign event_kind           = head.event_kind;
	assign first_data           = head.first_data;
	assign second_data          = head.second_data;
	assign meta_kind            = head.meta_kind;
	assign tempo_us_per_quarter = head.tempo_us_per_quarter;
	assign end_of_track         = head.end_of_track;
	assign error_code           = head.error_code;

endmodule
